/* hw/rtl/fbfl_pkg.sv */
package fbfl_pkg;

    // request codes
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // result status codes
    localparam logic STATUS_DONE  = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    localparam int IDX_W   = 6;
    localparam int ADDR_W  = 12;
    localparam int COUNT_W = 7;

    typedef struct packed {
        logic              kind;
        logic [IDX_W-1:0]  block_index;
    } req_t;

    typedef struct packed {
        logic               status;
        logic [IDX_W-1:0]   granted_index;
        logic [ADDR_W-1:0]  granted_address;
        logic [COUNT_W-1:0] blocks_in_use;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_POP
    } state_t;

endpackage

/* hw/rtl/fbfl_link_store.sv */
module fbfl_link_store #(
    parameter int NUM_BLOCKS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [$clog2(NUM_BLOCKS)-1:0]       wr_addr,
    input  logic [$clog2(NUM_BLOCKS+1)-1:0]     wr_data,
    input  logic                                rd_en,
    input  logic [$clog2(NUM_BLOCKS)-1:0]       rd_addr,
    output logic [$clog2(NUM_BLOCKS+1)-1:0]     rd_data,
    output logic                                ready
);
    localparam int AW = $clog2(NUM_BLOCKS);
    localparam int LW = $clog2(NUM_BLOCKS + 1);

    logic [LW-1:0] mem [NUM_BLOCKS];
    logic [LW-1:0] rd_data_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] clr_cnt_next;
    logic          clearing_reg;
    logic          clearing_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [LW-1:0] mem_wdata;

    // clearing sweep after reset: entry i gets i+1
    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == AW'(NUM_BLOCKS - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        if (clearing_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = LW'(clr_cnt_reg) + LW'(1);
        end
        else
        begin
            mem_we    = wr_en;
            mem_waddr = wr_addr;
            mem_wdata = wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clearing_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clearing_reg <= clearing_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign ready   = !clearing_reg;

endmodule

/* hw/rtl/fixed_block_free_list_allocator_top.sv */
// Fixed-size block pool kept as a LIFO free list. A request is taken on a clock
// edge with start high and busy low; its one result appears on rsp with done high
// for exactly one cycle and cannot be held off. A free request returns its result
// in the cycle after it is taken and busy stays low, so requests may come back to
// back. An allocate from a non-empty pool passes through ST_POP: the next link of
// the head is read from the registered link memory before the new head is known, so
// busy is high for one cycle. An allocate from an empty pool answers in the cycle
// after it is taken with the empty status. After reset the link memory is swept once
// to chain every block to the next, one entry per cycle, and ST_INIT then hands over
// to idle: busy stays high through the sweep and the handover.
module fixed_block_free_list_allocator_top #(
    parameter int NUM_BLOCKS  = 64,
    parameter int BLOCK_BYTES = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  fbfl_pkg::req_t req,
    output logic         done,
    output fbfl_pkg::rsp_t rsp
);
    import fbfl_pkg::*;

    localparam int AW = $clog2(NUM_BLOCKS);       // block index width
    localparam int LW = $clog2(NUM_BLOCKS + 1);   // link width, holds the null mark
    localparam int CW = $clog2(NUM_BLOCKS + 1);   // in-use count width
    localparam logic [LW-1:0] NULL_MARK = LW'(NUM_BLOCKS);

    state_t        state_reg;
    state_t        state_next;
    logic [LW-1:0] head_reg;
    logic [LW-1:0] head_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          done_reg;
    logic          done_next;
    rsp_t          rsp_reg;
    rsp_t          rsp_next;

    // link memory ports
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [LW-1:0] wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [LW-1:0] rd_data;
    logic          store_ready;

    logic          accept;
    logic          empty;
    logic          idx_ok;
    logic [LW-1:0] popped_link;
    logic [31:0]   head_wide;
    logic [31:0]   addr_wide;
    logic [31:0]   count_wide;

    fbfl_link_store #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_link_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .ready   (store_ready)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign empty  = (head_reg >= NULL_MARK);
    assign idx_ok = (32'(req.block_index) < NUM_BLOCKS);

    // a link above the null mark counts as the null mark
    assign popped_link = (rd_data > NULL_MARK) ? NULL_MARK : rd_data;

    // byte offset of the head block, kept to the result width
    assign head_wide  = 32'(head_reg);
    assign addr_wide  = head_wide * 32'(BLOCK_BYTES);
    assign count_wide = 32'(count_next);

    // the read is issued at accept, data comes back in ST_POP
    assign rd_en   = accept && (req.kind == KIND_ALLOC) && !empty;
    assign rd_addr = AW'(head_reg);

    // free pushes: link of the freed block takes the old head
    assign wr_en   = accept && (req.kind == KIND_FREE) && idx_ok;
    assign wr_addr = AW'(req.block_index);
    assign wr_data = head_reg;

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;

        case (state_reg)
            ST_INIT:
            begin
                if (store_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.kind == KIND_ALLOC)
                    begin
                        if (empty)
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_POP;
                        end
                    end
                    else
                    begin
                        done_next = 1'b1;
                        if (idx_ok)
                        begin
                            head_next = LW'(req.block_index);
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                    end
                end
            end
            ST_POP:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
                head_next  = popped_link;
                if (count_reg < CW'(NUM_BLOCKS))
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // result fields, only the pop grants a block
        rsp_next.blocks_in_use   = count_wide[COUNT_W-1:0];
        rsp_next.status          = (state_reg == ST_IDLE && empty) ? STATUS_EMPTY
                                                                    : STATUS_DONE;
        rsp_next.granted_index   = (state_reg == ST_POP) ? head_wide[IDX_W-1:0] : '0;
        rsp_next.granted_address = (state_reg == ST_POP) ? addr_wide[ADDR_W-1:0] : '0;
        if (!done_next)
        begin
            rsp_next = rsp_reg;
        end
        else if (state_reg == ST_IDLE && req.kind == KIND_FREE)
        begin
            rsp_next.status = STATUS_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            head_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // a pop always finishes with a result in the next cycle
    a_pop_answers: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_POP |=> done_reg)
        else $error("pop did not produce a result");

    // every result traces back to an accepted request or a finished pop
    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(accept) || $past(state_reg == ST_POP)))
        else $error("result without a request");

    // the head never points past the null mark
    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(head_reg) <= NUM_BLOCKS)
        else $error("free list head out of range");

    // the in-use count stays within the pool size
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= NUM_BLOCKS)
        else $error("in-use count out of range");

    // no request is taken while the link memory is being swept
    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        !store_ready |-> !accept)
        else $error("request taken during clearing sweep");

endmodule
